>>> rtl/toc_pkg.sv
package toc_pkg;

   // Build-time defaults for the top-level parameters.
   localparam int MAX_TRACKS_DEF  = 64;
   localparam int COORD_BITS_DEF  = 16;

   // Fixed field widths.
   localparam int MOTION_W        = 33;
   localparam int SUM_W           = 39;
   localparam int RATIO_W         = 24;
   localparam int RATIO_FRAC      = 16;
   localparam int TRACK_INDEX_W   = 6;
   localparam int KEPT_W          = 7;

   // Shared multiplier operand widths.
   localparam int MULT_A_W        = 40;
   localparam int MULT_B_W        = 24;

   // Register file.
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 33;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_REVERSE_CHECK_ENABLE = 3'd0;
   localparam csr_index_type CSR_REVERSE_LIMIT_SQ     = 3'd1;
   localparam csr_index_type CSR_CULL_ENABLE          = 3'd2;
   localparam csr_index_type CSR_MAX_RATIO            = 3'd3;
   localparam csr_index_type CSR_MIN_RATIO            = 3'd4;

   localparam logic                RESET_REVERSE_CHECK_ENABLE = 1'b1;
   localparam logic [MOTION_W-1:0] RESET_REVERSE_LIMIT_SQ     = 33'd256;
   localparam logic                RESET_CULL_ENABLE          = 1'b1;
   localparam logic [RATIO_W-1:0]  RESET_MAX_RATIO            = 24'd196608;
   localparam logic [RATIO_W-1:0]  RESET_MIN_RATIO            = 24'd655;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REV_X,
      ST_REV_Y,
      ST_MOT_X,
      ST_MOT_Y,
      ST_STORE,
      ST_PREP_U,
      ST_PREP_L,
      ST_PREP_W,
      ST_READ,
      ST_SCALE,
      ST_JUDGE,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      MUL_REV_X,
      MUL_REV_Y,
      MUL_MOT_X,
      MUL_MOT_Y,
      MUL_UPPER,
      MUL_LOWER,
      MUL_SCALE
   } mul_sel_type;

   typedef struct packed {
      logic req_valid;
      logic rsp_ready;
      logic full;
      logic empty;
      logic item_last;
      logic pass;
      logic last_entry;
   } status_type;

   typedef struct packed {
      logic        req_ready;
      logic        rsp_valid;
      logic        capture;
      mul_sel_type mul_sel;
      logic        acc_load;
      logic        rev_check;
      logic        store;
      logic        upper_load;
      logic        lower_load;
      logic        scan_start;
      logic        rd_en;
      logic        latch_valid;
      logic        judge;
      logic        rsp_take;
      logic        frame_clear;
   } ctrl_type;

endpackage

>>> rtl/track_outlier_cull_core.sv
// Forward-backward track check and motion outlier cull. Tracks are loaded one beat at a
// time; after the accept cycle each track goes through five sequencer steps (REV_X,
// REV_Y, MOT_X, MOT_Y, STORE), since all four squares go one after the other through a
// single registered 40x24 multiplier. A track beat with last_track set ends the frame:
// after setup in PREP_U, PREP_L and PREP_W (the two ratio bounds also go through the
// multiplier), a counting pass reads, scales and judges each loaded track, then an output
// pass does the same and holds each result beat until rsp_ready, one beat per loaded
// track in load order. No track is taken while a frame is being emitted. A track that
// arrives with the store full is dropped, but its last_track flag still ends the frame.
module track_outlier_cull_core
   import toc_pkg::*;
#(
   parameter int MAX_TRACKS = MAX_TRACKS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
)
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_tracked,
   input  logic                     req_reverse_ok,
   input  logic [COORD_BITS-1:0]    req_prev_x,
   input  logic [COORD_BITS-1:0]    req_prev_y,
   input  logic [COORD_BITS-1:0]    req_back_x,
   input  logic [COORD_BITS-1:0]    req_back_y,
   input  logic [COORD_BITS-1:0]    req_base_x,
   input  logic [COORD_BITS-1:0]    req_base_y,
   input  logic [COORD_BITS-1:0]    req_cur_x,
   input  logic [COORD_BITS-1:0]    req_cur_y,
   input  logic                     req_last_track,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [TRACK_INDEX_W-1:0] rsp_track_index,
   output logic                     rsp_keep,
   output logic [MOTION_W-1:0]      rsp_max_dist_sq,
   output logic [KEPT_W-1:0]        rsp_kept_count,
   output logic                     rsp_last_result,

   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  csr_index_type            csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data
);

   localparam int IDX_W   = $clog2(MAX_TRACKS);
   localparam int CNT_W   = $clog2(MAX_TRACKS + 1);
   localparam int SQ_W    = 2 * COORD_BITS + 1;
   localparam int EXT_W   = (SQ_W > MOTION_W) ? SQ_W : MOTION_W;
   localparam int PROD_W  = MULT_A_W + MULT_B_W;
   localparam int ENTRY_W = MOTION_W + 1;

   localparam logic [MOTION_W-1:0] MOTION_MAX = '1;

   function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
      logic [COORD_BITS-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return d;
   endfunction

   ctrl_type   ctrl;
   status_type status;

   // Configuration registers.
   logic                rev_en_ff;
   logic [MOTION_W-1:0] rev_limit_ff;
   logic                cull_en_ff;
   logic [RATIO_W-1:0]  max_ratio_ff;
   logic [RATIO_W-1:0]  min_ratio_ff;

   // Captured track.
   logic                  tracked_ff, reverse_ok_ff, last_ff;
   logic [COORD_BITS-1:0] prev_x_ff, prev_y_ff, back_x_ff, back_y_ff;
   logic [COORD_BITS-1:0] base_x_ff, base_y_ff, cur_x_ff, cur_y_ff;
   logic                  valid_ff, valid_in;
   logic [SQ_W-1:0]       acc_ff;

   // Frame statistics.
   logic [CNT_W-1:0]    loaded_ff;
   logic [CNT_W-1:0]    valid_cnt_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [MOTION_W-1:0] max_ff;

   // Scan state.
   logic [IDX_W-1:0]  idx_ff;
   logic              pass_ff;
   logic [CNT_W-1:0]  kept_ff;
   logic [PROD_W-1:0] upper_ff, lower_ff;
   logic              vbit_ff;

   logic [MULT_A_W-1:0] op_a;
   logic [MULT_B_W-1:0] op_b;
   logic [PROD_W-1:0]   prod_ff;

   logic [SQ_W-1:0]     dist_sum;
   logic [MOTION_W-1:0] motion;
   logic [PROD_W-1:0]   lhs;
   logic                keep_now;
   logic                last_entry;
   logic [ENTRY_W-1:0]  rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rev_en_ff    <= RESET_REVERSE_CHECK_ENABLE;
         rev_limit_ff <= RESET_REVERSE_LIMIT_SQ;
         cull_en_ff   <= RESET_CULL_ENABLE;
         max_ratio_ff <= RESET_MAX_RATIO;
         min_ratio_ff <= RESET_MIN_RATIO;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_REVERSE_CHECK_ENABLE: rev_en_ff    <= csr_data[0];
            CSR_REVERSE_LIMIT_SQ:     rev_limit_ff <= csr_data[MOTION_W-1:0];
            CSR_CULL_ENABLE:          cull_en_ff   <= csr_data[0];
            CSR_MAX_RATIO:            max_ratio_ff <= csr_data[RATIO_W-1:0];
            CSR_MIN_RATIO:            min_ratio_ff <= csr_data[RATIO_W-1:0];
            default:                  rev_en_ff    <= rev_en_ff;
         endcase
      end
   end

   assign last_entry = ((CNT_W'(idx_ff) + CNT_W'(1)) == loaded_ff);

   always_comb begin
      status            = '0;
      status.req_valid  = req_valid;
      status.rsp_ready  = rsp_ready;
      status.full       = (loaded_ff == CNT_W'(MAX_TRACKS));
      status.empty      = (loaded_ff == '0);
      status.item_last  = ctrl.capture ? req_last_track : last_ff;
      status.pass       = pass_ff;
      status.last_entry = last_entry;
   end

   toc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   assign req_ready = ctrl.req_ready;
   assign rsp_valid = ctrl.rsp_valid;

   // Operand selection for the shared multiplier.
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (ctrl.mul_sel)
         MUL_REV_X: begin
            op_a = MULT_A_W'(abs_diff(prev_x_ff, back_x_ff));
            op_b = MULT_B_W'(abs_diff(prev_x_ff, back_x_ff));
         end
         MUL_REV_Y: begin
            op_a = MULT_A_W'(abs_diff(prev_y_ff, back_y_ff));
            op_b = MULT_B_W'(abs_diff(prev_y_ff, back_y_ff));
         end
         MUL_MOT_X: begin
            op_a = MULT_A_W'(abs_diff(base_x_ff, cur_x_ff));
            op_b = MULT_B_W'(abs_diff(base_x_ff, cur_x_ff));
         end
         MUL_MOT_Y: begin
            op_a = MULT_A_W'(abs_diff(base_y_ff, cur_y_ff));
            op_b = MULT_B_W'(abs_diff(base_y_ff, cur_y_ff));
         end
         MUL_UPPER: begin
            op_a = MULT_A_W'(sum_ff);
            op_b = max_ratio_ff;
         end
         MUL_LOWER: begin
            op_a = MULT_A_W'(sum_ff);
            op_b = min_ratio_ff;
         end
         MUL_SCALE: begin
            op_a = MULT_A_W'(rd_data[MOTION_W-1:0]);
            op_b = MULT_B_W'(valid_cnt_ff);
         end
         default: op_a = '0;
      endcase
   end

   toc_mult #(
      .A_W (MULT_A_W),
      .B_W (MULT_B_W)
   ) u_mult (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod_ff)
   );

   // The second square of each pair lands while the first waits in the accumulator.
   assign dist_sum = acc_ff + SQ_W'(prod_ff[2*COORD_BITS-1:0]);
   assign motion   = (EXT_W'(dist_sum) > EXT_W'(MOTION_MAX)) ?
                     MOTION_MAX : MOTION_W'(EXT_W'(dist_sum));

   always_comb begin
      valid_in = tracked_ff;
      if (rev_en_ff && (!reverse_ok_ff || (EXT_W'(dist_sum) > EXT_W'(rev_limit_ff)))) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         tracked_ff    <= req_tracked;
         reverse_ok_ff <= req_reverse_ok;
         last_ff       <= req_last_track;
         prev_x_ff     <= req_prev_x;
         prev_y_ff     <= req_prev_y;
         back_x_ff     <= req_back_x;
         back_y_ff     <= req_back_y;
         base_x_ff     <= req_base_x;
         base_y_ff     <= req_base_y;
         cur_x_ff      <= req_cur_x;
         cur_y_ff      <= req_cur_y;
      end
      if (ctrl.acc_load) begin
         acc_ff <= SQ_W'(prod_ff[2*COORD_BITS-1:0]);
      end
      if (ctrl.rev_check) begin
         valid_ff <= valid_in;
      end
      if (ctrl.upper_load) begin
         upper_ff <= prod_ff;
      end
      if (ctrl.lower_load) begin
         lower_ff <= prod_ff;
      end
      if (ctrl.latch_valid) begin
         vbit_ff <= rd_data[MOTION_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff    <= '0;
         valid_cnt_ff <= '0;
         sum_ff       <= '0;
         max_ff       <= '0;
      end else if (ctrl.frame_clear) begin
         loaded_ff    <= '0;
         valid_cnt_ff <= '0;
         sum_ff       <= '0;
         max_ff       <= '0;
      end else if (ctrl.store) begin
         loaded_ff <= loaded_ff + CNT_W'(1);
         if (valid_ff) begin
            valid_cnt_ff <= valid_cnt_ff + CNT_W'(1);
            sum_ff       <= sum_ff + SUM_W'(motion);
            if (motion > max_ff) begin
               max_ff <= motion;
            end
         end
      end
   end

   toc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_TRACKS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ctrl.store),
      .wr_addr (loaded_ff[IDX_W-1:0]),
      .wr_data ({valid_ff, motion}),
      .rd_en   (ctrl.rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // d * k * 2^16 against sum * ratio, both sides exact.
   assign lhs      = prod_ff << RATIO_FRAC;
   assign keep_now = vbit_ff && (valid_cnt_ff != '0) &&
                     (!cull_en_ff || ((lhs <= upper_ff) && (lhs >= lower_ff)));

   // The first pass only counts kept tracks; the second sends one beat per track.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         pass_ff <= 1'b0;
         kept_ff <= '0;
      end else if (ctrl.scan_start) begin
         idx_ff  <= '0;
         pass_ff <= 1'b0;
         kept_ff <= '0;
      end else if (ctrl.judge && !pass_ff) begin
         kept_ff <= kept_ff + CNT_W'(keep_now);
         if (last_entry) begin
            idx_ff  <= '0;
            pass_ff <= 1'b1;
         end else begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
      end else if (ctrl.rsp_take && !last_entry) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.judge && pass_ff) begin
         rsp_track_index <= TRACK_INDEX_W'(idx_ff);
         rsp_keep        <= keep_now;
         rsp_max_dist_sq <= max_ff;
         rsp_kept_count  <= KEPT_W'(kept_ff);
         rsp_last_result <= last_entry;
      end
   end

endmodule

>>> rtl/toc_ram.sv
module toc_ram
#(
   parameter int WIDTH = 34,
   parameter int DEPTH = 64
)
(
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> rtl/toc_mult.sv
module toc_mult
   import toc_pkg::*;
#(
   parameter int A_W = MULT_A_W,
   parameter int B_W = MULT_B_W
)
(
   input  logic               clock,
   input  logic [A_W-1:0]     op_a,
   input  logic [B_W-1:0]     op_b,
   output logic [A_W+B_W-1:0] prod_ff
);

   logic [A_W+B_W-1:0] prod_in;

   assign prod_in = (A_W+B_W)'(op_a) * (A_W+B_W)'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

>>> rtl/toc_ctrl.sv
module toc_ctrl
   import toc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output ctrl_type   ctrl
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (status.req_valid) begin
               if (!status.full) begin
                  state_in = ST_REV_X;
               end else if (status.item_last) begin
                  state_in = ST_PREP_U;
               end
            end
         end
         ST_REV_X:  state_in = ST_REV_Y;
         ST_REV_Y:  state_in = ST_MOT_X;
         ST_MOT_X:  state_in = ST_MOT_Y;
         ST_MOT_Y:  state_in = ST_STORE;
         ST_STORE:  state_in = status.item_last ? ST_PREP_U : ST_IDLE;
         ST_PREP_U: state_in = ST_PREP_L;
         ST_PREP_L: state_in = ST_PREP_W;
         ST_PREP_W: state_in = status.empty ? ST_IDLE : ST_READ;
         ST_READ:   state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_JUDGE;
         ST_JUDGE:  state_in = status.pass ? ST_OUT : ST_READ;
         ST_OUT: begin
            if (status.rsp_ready) begin
               state_in = status.last_entry ? ST_IDLE : ST_READ;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      ctrl.mul_sel = MUL_SCALE;
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.req_ready = 1'b1;
            ctrl.capture   = status.req_valid;
         end
         ST_REV_X: ctrl.mul_sel = MUL_REV_X;
         ST_REV_Y: begin
            ctrl.mul_sel  = MUL_REV_Y;
            ctrl.acc_load = 1'b1;
         end
         ST_MOT_X: begin
            ctrl.mul_sel   = MUL_MOT_X;
            ctrl.rev_check = 1'b1;
         end
         ST_MOT_Y: begin
            ctrl.mul_sel  = MUL_MOT_Y;
            ctrl.acc_load = 1'b1;
         end
         ST_STORE:  ctrl.store = 1'b1;
         ST_PREP_U: ctrl.mul_sel = MUL_UPPER;
         ST_PREP_L: begin
            ctrl.mul_sel    = MUL_LOWER;
            ctrl.upper_load = 1'b1;
         end
         ST_PREP_W: begin
            ctrl.lower_load  = 1'b1;
            ctrl.scan_start  = 1'b1;
            ctrl.frame_clear = status.empty;
         end
         ST_READ:  ctrl.rd_en = 1'b1;
         ST_SCALE: begin
            ctrl.mul_sel     = MUL_SCALE;
            ctrl.latch_valid = 1'b1;
         end
         ST_JUDGE: ctrl.judge = 1'b1;
         ST_OUT: begin
            ctrl.rsp_valid   = 1'b1;
            ctrl.rsp_take    = status.rsp_ready;
            ctrl.frame_clear = status.rsp_ready & status.last_entry;
         end
         default: ctrl.req_ready = 1'b0;
      endcase
   end

endmodule
